@@ design/utt_pkg.sv @@
// Shared types and constants of the UTF-16/Latin-1 to UTF-8 transcoder.
package utt_pkg;

    localparam int UNIT_W = 16;
    localparam int CP_W   = 21;
    localparam int BYTE_W = 8;

    localparam logic [UNIT_W-1:0] HIGH_FIRST = 16'hd800;
    localparam logic [UNIT_W-1:0] HIGH_LAST  = 16'hdbff;
    localparam logic [UNIT_W-1:0] LOW_FIRST  = 16'hdc00;
    localparam logic [UNIT_W-1:0] LOW_LAST   = 16'hdfff;
    localparam logic [CP_W-1:0]   SUPP_BASE  = 21'h10000;
    localparam logic [CP_W-1:0]   LIMIT_1B   = 21'h80;
    localparam logic [CP_W-1:0]   LIMIT_2B   = 21'h800;
    localparam logic [CP_W-1:0]   LIMIT_3B   = 21'h10000;

    localparam logic [BYTE_W-1:0] LEAD_2B = 8'hc0;
    localparam logic [BYTE_W-1:0] LEAD_3B = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD_4B = 8'hf0;
    localparam logic [BYTE_W-1:0] CONT_B  = 8'h80;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_TERM  = 2'd1,
        STATUS_BAD_SURR = 2'd2
    } status_t;

    // One unit of work for the byte serializer: a code point to encode or a done marker.
    typedef struct packed {
        logic            done;
        status_t         status;
        logic [CP_W-1:0] cp;
        logic [1:0]      len_m1;
    } job_t;

endpackage

@@ design/utt_front.sv @@
// Front end: accepts code units, tracks surrogate and error state, emits jobs.
module utt_front
    import utt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [UNIT_W-1:0] code_unit,
    input  logic              wide_mode,
    input  logic              final_unit,
    input  logic              queue_full,
    output logic              job_push,
    output job_t              job
);

    logic       pending_reg, pending_next;
    logic [9:0] held_reg, held_next;
    logic       skip_reg, skip_next;

    logic [UNIT_W-1:0] unit;
    logic              is_high, is_low, accept;
    logic [CP_W-1:0]   pair_cp, char_cp;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign unit     = wide_mode ? code_unit : {8'h00, code_unit[7:0]};
    assign is_high  = wide_mode && (unit >= HIGH_FIRST) && (unit <= HIGH_LAST);
    assign is_low   = wide_mode && (unit >= LOW_FIRST) && (unit <= LOW_LAST);
    assign pair_cp  = {1'b0, held_reg, unit[9:0]} + SUPP_BASE;

    function automatic job_t char_job(input logic [CP_W-1:0] cp);
        job_t j;
        j.done   = 1'b0;
        j.status = STATUS_OK;
        j.cp     = cp;
        if (cp < LIMIT_1B) begin
            j.len_m1 = 2'd0;
        end else if (cp < LIMIT_2B) begin
            j.len_m1 = 2'd1;
        end else if (cp < LIMIT_3B) begin
            j.len_m1 = 2'd2;
        end else begin
            j.len_m1 = 2'd3;
        end
        return j;
    endfunction

    function automatic job_t done_job(input status_t st);
        job_t j;
        j.done   = 1'b1;
        j.status = st;
        j.cp     = '0;
        j.len_m1 = 2'd0;
        return j;
    endfunction

    assign char_cp = {5'd0, unit};

    always_comb begin
        pending_next = pending_reg;
        held_next    = held_reg;
        skip_next    = skip_reg;
        job_push     = 1'b0;
        job          = done_job(STATUS_OK);
        if (accept) begin
            priority if (skip_reg) begin
                if (final_unit) begin
                    skip_next = 1'b0;
                end
            end else if (final_unit) begin
                job_push     = 1'b1;
                pending_next = 1'b0;
                held_next    = '0;
                if (unit != '0) begin
                    job = done_job(STATUS_NO_TERM);
                end else if (pending_reg) begin
                    job = done_job(STATUS_BAD_SURR);
                end else begin
                    job = done_job(STATUS_OK);
                end
            end else if (pending_reg) begin
                job_push     = 1'b1;
                pending_next = 1'b0;
                held_next    = '0;
                if (is_low) begin
                    job = char_job(pair_cp);
                end else begin
                    job       = done_job(STATUS_BAD_SURR);
                    skip_next = 1'b1;
                end
            end else if (is_low) begin
                job_push  = 1'b1;
                job       = done_job(STATUS_BAD_SURR);
                skip_next = 1'b1;
            end else if (is_high) begin
                // Hold the high half until its partner arrives.
                pending_next = 1'b1;
                held_next    = unit[9:0];
            end else begin
                job_push = 1'b1;
                job      = char_job(char_cp);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
            held_reg    <= '0;
            skip_reg    <= 1'b0;
        end else begin
            pending_reg <= pending_next;
            held_reg    <= held_next;
            skip_reg    <= skip_next;
        end
    end

endmodule

@@ design/utt_fifo.sv @@
// Small register queue of jobs between the front end and the byte serializer.
module utt_fifo
    import utt_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output job_t pop_data,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ design/utt_back.sv @@
// Back end: splits each job into UTF-8 bytes, one registered result item per cycle while the receiver is ready.
module utt_back
    import utt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              queue_empty,
    input  job_t              job,
    output logic              job_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] utf8_byte,
    output logic              byte_present,
    output logic              run_end,
    output logic              string_done,
    output status_t           status
);

    logic [1:0]        idx_reg, idx_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              present_reg, last_reg, done_reg;
    status_t           status_reg;

    logic              load, last_byte;
    logic [BYTE_W-1:0] sel_byte;

    assign load      = !queue_empty && (!valid_reg || m_tready);
    assign last_byte = (idx_reg == job.len_m1);
    assign job_pop   = load && last_byte;

    always_comb begin
        unique case ({job.len_m1, idx_reg})
            4'b00_00: sel_byte = {1'b0, job.cp[6:0]};
            4'b01_00: sel_byte = LEAD_2B | {3'b000, job.cp[10:6]};
            4'b10_00: sel_byte = LEAD_3B | {4'h0, job.cp[15:12]};
            4'b11_00: sel_byte = LEAD_4B | {5'd0, job.cp[20:18]};
            4'b11_01: sel_byte = CONT_B | {2'b00, job.cp[17:12]};
            4'b10_01, 4'b11_10: sel_byte = CONT_B | {2'b00, job.cp[11:6]};
            4'b01_01, 4'b10_10, 4'b11_11: sel_byte = CONT_B | {2'b00, job.cp[5:0]};
            default: sel_byte = '0;
        endcase
        if (job.done) begin
            sel_byte = '0;
        end
    end

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = last_byte ? 2'd0 : idx_reg + 2'd1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg    <= sel_byte;
            present_reg <= !job.done;
            last_reg    <= last_byte;
            done_reg    <= job.done;
            status_reg  <= job.status;
        end
    end

    assign m_tvalid     = valid_reg;
    assign utf8_byte    = byte_reg;
    assign byte_present = present_reg;
    assign run_end      = last_reg;
    assign string_done  = done_reg;
    assign status       = status_reg;

endmodule

@@ design/utf16_to_utf8_transcoder_core.sv @@
// Top level of the UTF-16LE / Latin-1 to UTF-8 transcoder.
//
// Input stream (s_): one code unit of a zero-terminated string per item.
// tdata carries the 16-bit unit, tuser says the unit is wide UTF-16LE (1)
// or a Latin-1 byte (0), and tlast marks the terminating unit.
// Output stream (m_): one result item per cycle while m_tready is high. tdata is a UTF-8 byte;
// tuser carries byte_present, string_done and the 2-bit status; tlast ends
// the run of results caused by one input item.
//
// An input unit becomes one to four bytes; a high surrogate yields nothing
// until its low partner arrives, and the terminator yields one done item.
// After a surrogate error one done item reports it and units are dropped
// up to the next tlast. The front end takes one item per cycle into a
// FIFO_DEPTH-entry job queue unless it is full; the serializer sends one byte
// per cycle while the receiver is ready; a job yields one to four results
// (four above U+FFFF). An item goes through the job queue, then the output
// register. When the receiver stalls, the output register holds its item and
// the queue fills, after which s_tready drops. A synchronous reset empties the
// queue and clears the output valid flag and all surrogate and error state.
module utf16_to_utf8_transcoder_core
    import utt_pkg::*;
#(
    parameter int FIFO_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [15:0] code_unit
    input  logic        s_tuser,  // [0] wide_mode
    input  logic        s_tlast,  // final_unit
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // [7:0] utf8_byte
    output logic [3:0]  m_tuser,  // [0] byte_present, [1] string_done, [3:2] status
    output logic        m_tlast   // run_end
);

    job_t    push_job, head_job;
    logic    push, pop, full, empty;
    logic    byte_present, string_done;
    status_t status;

    utt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .code_unit  (s_tdata),
        .wide_mode  (s_tuser),
        .final_unit (s_tlast),
        .queue_full (full),
        .job_push   (push),
        .job        (push_job)
    );

    utt_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_job),
        .full      (full),
        .pop       (pop),
        .pop_data  (head_job),
        .empty     (empty)
    );

    utt_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .queue_empty  (empty),
        .job          (head_job),
        .job_pop      (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .utf8_byte    (m_tdata),
        .byte_present (byte_present),
        .run_end      (m_tlast),
        .string_done  (string_done),
        .status       (status)
    );

    assign m_tuser = {status, string_done, byte_present};

endmodule

@@ design/utt_checker.sv @@
// Port-level checks on the transcoder's result stream, bound to the top level.
module utt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [3:0] m_tuser,
    input logic       m_tlast
);

    // A stalled result item keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result item changed");

    // The done item is always the last one of its run and carries no byte.
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0] && (m_tdata == 8'h00))
        else $error("done item malformed");

    // Every item is either a byte or a done item.
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] != m_tuser[1]))
        else $error("item is neither byte nor done");

    // Byte items report ok status, and no status code above 2 appears.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[3:2] != 2'd3) && (m_tuser[1] || (m_tuser[3:2] == 2'd0)))
        else $error("bad status on result item");

endmodule

bind utf16_to_utf8_transcoder_core utt_checker u_checker (.*);

@@ test/tb_top.sv @@
// Self-checking testbench for the UTF-16LE / Latin-1 to UTF-8 transcoder core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import utt_pkg::*;

    typedef struct {
        logic [7:0] octet;
        logic       has_byte;
        logic       done;
        status_t    status;
        logic       last_of_run;
    } utf8_item_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;  // [15:0] code_unit
    logic        s_tuser  = 1'b0;  // [0] wide_mode
    logic        s_tlast  = 1'b0;  // final_unit
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;  // [7:0] utf8_byte
    logic [3:0]  m_tuser;  // [0] byte_present, [1] string_done, [3:2] status
    logic        m_tlast;  // run_end

    // Shadow of the transcoder's surrogate and error state.
    logic [9:0]  held_bits    = '0;
    logic        high_waiting = 1'b0;
    logic        dropping     = 1'b0;

    utf8_item_t  expected_utf8[$];
    utf8_item_t  want;
    logic        calm = 1'b0;
    int          sent_items = 0;
    int          errors = 0;

    utf16_to_utf8_transcoder_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic void queue_item(utf8_item_t it);
        expected_utf8 = {expected_utf8, it};
    endfunction

    function automatic void end_string(status_t st, logic fin);
        queue_item('{octet: 8'h00, has_byte: 1'b0, done: 1'b1,
                     status: st, last_of_run: 1'b1});
        held_bits    = '0;
        high_waiting = 1'b0;
        dropping     = !fin;
    endfunction

    function automatic void push_utf8(logic [20:0] cp);
        logic [7:0] seq[4];
        int         n;
        if (cp < LIMIT_1B) begin
            seq[0] = cp[7:0];
            n = 1;
        end else if (cp < LIMIT_2B) begin
            seq[0] = LEAD_2B | {3'b000, cp[10:6]};
            seq[1] = CONT_B | {2'b00, cp[5:0]};
            n = 2;
        end else if (cp < LIMIT_3B) begin
            seq[0] = LEAD_3B | {4'h0, cp[15:12]};
            seq[1] = CONT_B | {2'b00, cp[11:6]};
            seq[2] = CONT_B | {2'b00, cp[5:0]};
            n = 3;
        end else begin
            seq[0] = LEAD_4B | {5'd0, cp[20:18]};
            seq[1] = CONT_B | {2'b00, cp[17:12]};
            seq[2] = CONT_B | {2'b00, cp[11:6]};
            seq[3] = CONT_B | {2'b00, cp[5:0]};
            n = 4;
        end
        for (int k = 0; k < n; k++)
            queue_item('{octet: seq[k], has_byte: 1'b1, done: 1'b0,
                         status: STATUS_OK, last_of_run: k == n - 1});
    endfunction

    function automatic void predict_utf8(logic [15:0] unit_in, logic wide, logic fin);
        logic [15:0] u;
        logic        is_hi;
        logic        is_lo;
        logic [20:0] cp;
        u     = wide ? unit_in : {8'h00, unit_in[7:0]};
        is_hi = wide && u >= HIGH_FIRST && u <= HIGH_LAST;
        is_lo = wide && u >= LOW_FIRST && u <= LOW_LAST;
        if (dropping) begin
            if (fin)
                dropping = 1'b0;
            return;
        end
        if (fin) begin
            // A nonzero terminator outranks a dangling high surrogate.
            if (u != 0)
                end_string(STATUS_NO_TERM, 1'b1);
            else if (high_waiting)
                end_string(STATUS_BAD_SURR, 1'b1);
            else
                end_string(STATUS_OK, 1'b1);
        end else if (high_waiting) begin
            if (!is_lo) begin
                end_string(STATUS_BAD_SURR, 1'b0);
            end else begin
                cp = SUPP_BASE + {held_bits, 10'b0} + (u - LOW_FIRST);
                held_bits    = '0;
                high_waiting = 1'b0;
                push_utf8(cp);
            end
        end else if (is_lo) begin
            end_string(STATUS_BAD_SURR, 1'b0);
        end else if (is_hi) begin
            held_bits    = u[9:0];
            high_waiting = 1'b1;
        end else begin
            push_utf8({5'b0, u});
        end
    endfunction

    function automatic void check_field(string name, int unsigned exp, int unsigned act);
        if (exp != act) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, exp, act);
            errors++;
        end
    endfunction

    // Receiver: random backpressure and comparison of every accepted result item.
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 36);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_utf8.size() == 0) begin
                $display("%0t ns: unexpected item, expected none, got tdata %0h tuser %0h tlast %0b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                want = expected_utf8.pop_front();
                check_field("utf8_byte", want.octet, m_tdata);
                check_field("byte_present", want.has_byte, m_tuser[0]);
                check_field("string_done", want.done, m_tuser[1]);
                check_field("status", want.status, m_tuser[3:2]);
                check_field("run_end", want.last_of_run, m_tlast);
            end
        end
    end

    task automatic send_unit(logic [15:0] u, logic wide, logic fin);
        while (!calm && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= u;
        s_tuser  <= wide;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        predict_utf8(u, wide, fin);
        sent_items++;
    endtask

    task automatic send_terminator();
        logic wide;
        wide = 1'($urandom_range(1));
        // A narrow terminator only looks at its low byte.
        send_unit(wide ? 16'h0000 : {8'($urandom_range(255)), 8'h00}, wide, 1'b1);
    endtask

    task automatic send_char();
        case ($urandom_range(4))
            0: send_unit(16'($urandom_range(16'hffff)), 1'b0, 1'b0);
            1: send_unit(16'($urandom_range(16'h007f)), 1'b1, 1'b0);
            2: send_unit(16'($urandom_range(16'h07ff, 16'h0080)), 1'b1, 1'b0);
            3: begin
                if ($urandom_range(1))
                    send_unit(16'($urandom_range(16'hd7ff, 16'h0800)), 1'b1, 1'b0);
                else
                    send_unit(16'($urandom_range(16'hffff, 16'he000)), 1'b1, 1'b0);
            end
            default: begin
                send_unit(16'($urandom_range(16'hdbff, 16'hd800)), 1'b1, 1'b0);
                send_unit(16'($urandom_range(16'hdfff, 16'hdc00)), 1'b1, 1'b0);
            end
        endcase
    endtask

    task automatic send_noise();
        int   pick;
        logic fin;
        pick = $urandom_range(99);
        fin  = $urandom_range(99) < 8;
        if (pick < 50)
            send_unit(16'($urandom_range(16'hffff)), 1'($urandom_range(1)), fin);
        else if (pick < 80)
            send_unit(16'($urandom_range(16'hdfff, 16'hd800)), 1'b1, fin);
        else
            send_unit(16'($urandom_range(16'hffff)), 1'b0, fin);
    endtask

    task automatic test_encoding_lengths();
        send_unit(16'h0000, 1'b0, 1'b0);  // zero unit that is not the terminator
        send_unit(16'hff41, 1'b0, 1'b0);  // upper byte ignored in narrow mode
        send_unit(16'h00ff, 1'b0, 1'b0);
        send_unit(16'h007f, 1'b1, 1'b0);
        send_unit(16'h0080, 1'b1, 1'b0);
        send_unit(16'h07ff, 1'b1, 1'b0);
        send_unit(16'h0800, 1'b1, 1'b0);
        send_unit(16'hffff, 1'b1, 1'b0);
    endtask

    task automatic test_surrogate_pairs();
        send_unit(16'hd800, 1'b1, 1'b0);
        send_unit(16'hdc00, 1'b1, 1'b0);
        send_unit(16'hdbff, 1'b1, 1'b0);
        send_unit(16'hdfff, 1'b1, 1'b0);
        send_unit(16'hff00, 1'b0, 1'b1);
    endtask

    task automatic test_terminator_errors();
        send_unit(16'h0041, 1'b1, 1'b1);
        send_unit(16'hd800, 1'b1, 1'b0);
        send_unit(16'h0000, 1'b1, 1'b1);
        send_unit(16'hdbff, 1'b1, 1'b0);
        send_unit(16'hdc00, 1'b1, 1'b1);
    endtask

    task automatic test_surrogate_errors();
        send_unit(16'hdc00, 1'b1, 1'b0);  // lone low surrogate starts recovery
        send_unit(16'h0041, 1'b1, 1'b0);
        send_unit(16'h1234, 1'b1, 1'b1);
        send_unit(16'hd800, 1'b1, 1'b0);
        send_unit(16'h0041, 1'b0, 1'b0);  // narrow unit cannot pair
        send_unit(16'h0000, 1'b0, 1'b1);
        send_unit(16'hd800, 1'b1, 1'b0);
        send_unit(16'hdbff, 1'b1, 1'b0);
        send_unit(16'h0000, 1'b1, 1'b1);
    endtask

    task automatic test_random_strings();
        int start;
        int n;
        start = sent_items;
        calm <= 1'b1;
        while (sent_items < 220) begin
            if (sent_items - start >= 60)
                calm <= 1'b0;
            if ($urandom_range(99) < 75) begin
                n = $urandom_range(7);
                repeat (n) send_char();
                send_terminator();
            end else begin
                n = $urandom_range(6, 1);
                repeat (n) send_noise();
                if ($urandom_range(1))
                    send_terminator();
                else
                    send_unit(16'($urandom_range(16'hffff)), 1'($urandom_range(1)), 1'b1);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_encoding_lengths();
        test_surrogate_pairs();
        test_terminator_errors();
        test_surrogate_errors();
        test_random_strings();
        s_tvalid <= 1'b0;
        while (expected_utf8.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
